// ===== sv/population_median_diversity_macros.svh =====
// Assertion macros for the population median diversity block.
`ifndef POPULATION_MEDIAN_DIVERSITY_MACROS_SVH
`define POPULATION_MEDIAN_DIVERSITY_MACROS_SVH
`ifndef SYNTHESIS
`define PMD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PMD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PMD_ASSERT_IMPLY(label, ante, cons)
`define PMD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/pmd_pkg.sv =====
// Shared constants and types for the population median diversity block.
package pmd_pkg;
	localparam int MAX_AGENTS  = 64;
	localparam int MAX_DIMS    = 32;
	localparam int STORE_DEPTH = MAX_AGENTS * MAX_DIMS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = 12;
	localparam int AG_W        = 7;
	localparam int DM_W        = 6;
	localparam int DVD_W       = 38;
	localparam int DIVR_W      = 7;
	localparam int DCNT_W      = 6;

	localparam logic [1:0] REG_AGENT_COUNT = 2'd0;
	localparam logic [1:0] REG_DIM_COUNT   = 2'd1;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} pmd_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} pmd_div_rsp_t;
endpackage

// ===== sv/pmd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pmd_div
	import pmd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  pmd_div_req_t req,
	output pmd_div_rsp_t rsp
);
	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] div_q;
	logic [DIVR_W:0]   sh;
	logic              qbit;
	logic [DIVR_W:0]   diff;

	// Trial subtraction of the divisor from the shifted remainder
	always_comb begin
		sh   = {rem_q, dvd_q[DVD_W-1]};
		diff = sh - {1'b0, div_q};
		qbit = (sh >= {1'b0, div_q});
	end

	// Step through the dividend from the top bit down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvd_q  <= req.dividend;
				div_q  <= req.divisor;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				rem_q <= qbit ? diff[DIVR_W-1:0] : sh[DIVR_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], qbit};
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

// ===== sv/population_median_diversity.sv =====
// Loading takes one coordinate per cycle while the block is in its load state and the
// output is free; a wrong item count gives its result in the cycle after the last item.
// Otherwise each dimension tries the column's agents in turn as candidates, reading every agent of the
// column for each candidate through the single-port store, then divides the sum.
// A new set is loaded only after the previous one has been computed and averaged.
// Reset: arst_n clears control, item count and registers (A=1, D=1); store undefined.
`include "population_median_diversity_macros.svh"
module population_median_diversity
	import pmd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] coord
	input  logic        s_tlast,  // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] diversity
	output logic        m_tuser,  // [0] count_error
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [6:0]  cfg_wdata
);
	typedef enum logic [7:0] {
		ST_LOAD = 8'b00000001,
		ST_CRD  = 8'b00000010,
		ST_CCAP = 8'b00000100,
		ST_CMP  = 8'b00001000,
		ST_CHK  = 8'b00010000,
		ST_DEV  = 8'b00100000,
		ST_DIVA = 8'b01000000,
		ST_DIVD = 8'b10000000
	} st_t;

	st_t              st_q;
	logic [AG_W-1:0]  agent_q;
	logic [DM_W-1:0]  dim_q;
	logic [AG_W-1:0]  na;
	logic [DM_W-1:0]  nd;
	logic [AG_W-1:0]  k;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nx;
	logic [CNT_W-1:0] expected;
	logic             in_acc;
	logic             out_free;
	logic             out_set;
	logic             div_start_nx;

	logic [31:0]      mem [STORE_DEPTH];
	logic [31:0]      rdata_q;
	logic [CNT_W-1:0] raddr;
	logic             rd_en;

	logic [DM_W-1:0]  d_q;
	logic [CNT_W-1:0] cand_addr_q;
	logic [CNT_W-1:0] addr_q;
	logic [AG_W-1:0]  iss_q;
	logic [AG_W-1:0]  proc_q;
	logic             vld_s1;
	logic [31:0]      cand_q;
	logic [31:0]      med_q;
	logic [AG_W-1:0]  less_q;
	logic [AG_W-1:0]  eq_q;
	logic [AG_W:0]    le_sum;
	logic [DVD_W-1:0] sum_q;
	logic [DVD_W-1:0] total_q;
	logic             div_start_q;
	logic [32:0]      dev;
	logic [31:0]      dev_abs;
	logic             issue;
	logic             found;

	logic             out_vld_q;
	logic [31:0]      out_div_q;
	logic             out_err_q;

	pmd_div_req_t     dreq;
	pmd_div_rsp_t     drsp;

	// Clamp register values to their legal ranges
	always_comb begin
		na = agent_q;
		if (agent_q == '0) na = AG_W'(1);
		else if (agent_q > AG_W'(MAX_AGENTS)) na = AG_W'(MAX_AGENTS);
		nd = dim_q;
		if (dim_q == '0) nd = DM_W'(1);
		else if (dim_q > DM_W'(MAX_DIMS)) nd = DM_W'(MAX_DIMS);
		k = na >> 1;
	end

	assign expected = CNT_W'(na) * CNT_W'(nd);
	assign cnt_nx   = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (st_q == ST_LOAD) && out_free;
	assign in_acc   = s_tvalid && s_tready;

	// Raise a result on a count error or when the final quotient arrives
	assign out_set = (in_acc && s_tlast && (cnt_nx != expected))
		|| ((st_q == ST_DIVD) && drsp.done);

	// Start the divider after a column sum and after the last dimension
	assign div_start_nx = ((st_q == ST_DEV) && (proc_q == na))
		|| ((st_q == ST_DIVA) && drsp.done && (d_q + 1'b1 == nd));

	// Scan issue, store read address and per-element arithmetic
	always_comb begin
		issue   = ((st_q == ST_CMP) || (st_q == ST_DEV)) && (iss_q < na);
		rd_en   = issue || (st_q == ST_CRD);
		raddr   = (st_q == ST_CRD) ? cand_addr_q : addr_q;
		dev     = {med_q[31], med_q} - {rdata_q[31], rdata_q};
		dev_abs = dev[32] ? 32'(-dev) : dev[31:0];
		le_sum  = {1'b0, less_q} + {1'b0, eq_q};
		found   = (less_q <= k) && ({1'b0, k} < le_sum);
	end

	// Position store: write while loading, read during compute
	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CNT_W'(STORE_DEPTH)))
			mem[cnt_q[ADDR_W-1:0]] <= s_tdata;
		if (rd_en)
			rdata_q <= mem[raddr[ADDR_W-1:0]];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agent_q <= AG_W'(1);
			dim_q   <= DM_W'(1);
		end else if (cfg_we) begin
			if (cfg_idx == REG_AGENT_COUNT) agent_q <= cfg_wdata;
			else if (cfg_idx == REG_DIM_COUNT) dim_q <= cfg_wdata[DM_W-1:0];
		end
	end

	assign dreq.start    = div_start_q;
	assign dreq.dividend = (st_q == ST_DIVD) ? total_q : sum_q;
	assign dreq.divisor  = (st_q == ST_DIVD) ? DIVR_W'(nd) : DIVR_W'(na);

	pmd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Main sequencer: load, select median per column, sum deviations, divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_LOAD;
			cnt_q       <= '0;
			d_q         <= '0;
			cand_addr_q <= '0;
			addr_q      <= '0;
			iss_q       <= '0;
			proc_q      <= '0;
			vld_s1      <= 1'b0;
			cand_q      <= '0;
			med_q       <= '0;
			less_q      <= '0;
			eq_q        <= '0;
			sum_q       <= '0;
			total_q     <= '0;
			div_start_q <= 1'b0;
			out_vld_q   <= 1'b0;
			out_div_q   <= '0;
			out_err_q   <= 1'b0;
		end else begin
			div_start_q <= div_start_nx;

			// Hold the result until the transaction completes
			if (out_set) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;

			// Advance the read pipeline of a column scan
			vld_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + CNT_W'(nd);
				iss_q  <= iss_q + 1'b1;
			end

			unique case (st_q)
				ST_LOAD: begin
					if (in_acc) begin
						cnt_q <= s_tlast ? '0 : cnt_nx;
						if (s_tlast) begin
							if (cnt_nx != expected) begin
								out_div_q <= '0;
								out_err_q <= 1'b1;
							end else begin
								d_q         <= '0;
								cand_addr_q <= '0;
								total_q     <= '0;
								st_q        <= ST_CRD;
							end
						end
					end
				end
				ST_CRD: st_q <= ST_CCAP;
				ST_CCAP: begin
					cand_q <= rdata_q;
					less_q <= '0;
					eq_q   <= '0;
					addr_q <= CNT_W'(d_q);
					iss_q  <= '0;
					proc_q <= '0;
					st_q   <= ST_CMP;
				end
				ST_CMP: begin
					if (vld_s1) begin
						proc_q <= proc_q + 1'b1;
						if ($signed(rdata_q) < $signed(cand_q)) less_q <= less_q + 1'b1;
						if (rdata_q == cand_q) eq_q <= eq_q + 1'b1;
					end
					if (proc_q == na) st_q <= ST_CHK;
				end
				ST_CHK: begin
					if (found) begin
						med_q  <= cand_q;
						sum_q  <= '0;
						addr_q <= CNT_W'(d_q);
						iss_q  <= '0;
						proc_q <= '0;
						st_q   <= ST_DEV;
					end else begin
						cand_addr_q <= cand_addr_q + CNT_W'(nd);
						st_q        <= ST_CRD;
					end
				end
				ST_DEV: begin
					if (vld_s1) begin
						proc_q <= proc_q + 1'b1;
						sum_q  <= sum_q + DVD_W'(dev_abs);
					end
					if (proc_q == na) st_q <= ST_DIVA;
				end
				ST_DIVA: begin
					if (drsp.done) begin
						total_q <= total_q + drsp.quotient;
						if (d_q + 1'b1 == nd) begin
							st_q <= ST_DIVD;
						end else begin
							d_q         <= d_q + 1'b1;
							cand_addr_q <= CNT_W'(d_q + 1'b1);
							st_q        <= ST_CRD;
						end
					end
				end
				ST_DIVD: begin
					if (drsp.done) begin
						out_div_q <= drsp.quotient[31:0];
						out_err_q <= 1'b0;
						st_q      <= ST_LOAD;
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_div_q;
	assign m_tuser  = out_err_q;

	// An error result carries zero diversity
	`PMD_ASSERT_IMPLY(a_err_zero, m_tvalid && m_tuser, m_tdata == 32'd0)
	// Scan never issues more reads than agents in the column
	`PMD_ASSERT_IMPLY(a_iss_bound, st_q == ST_CMP || st_q == ST_DEV, iss_q <= na)
	// Rank counts at the check stay within the column size
	`PMD_ASSERT_IMPLY(a_rank_bound, st_q == ST_CHK, le_sum <= {1'b0, na})
	// A divider start is followed by waiting for its quotient
	`PMD_ASSERT_NEXT(a_div_wait, div_start_q, st_q == ST_DIVA || st_q == ST_DIVD)
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the population median diversity block.
module tb_top;
	import pmd_pkg::*;

	localparam int          WDOG_LIMIT    = 1000000;
	localparam int          IDLE_SETTLE   = 120;
	localparam int          RANDOM_ITEMS  = 400;
	localparam logic [1:0]  REG_SPARE_A   = 2'd2;
	localparam logic [1:0]  REG_SPARE_B   = 2'd3;
	localparam int          CNT_SAT       = 4095;

	typedef struct {
		logic [31:0] coord;
		logic        last;
		bit          fixed;     // expected result given below, not predicted
		logic [31:0] fixed_div;
		logic        fixed_err;
	} coord_txn_t;

	typedef struct {
		logic [31:0] div;
		logic        err;
	} div_result_t;

	typedef struct {
		int          agents;
		int          dims;
		coord_txn_t  txn;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] coord
	logic        s_tlast = 1'b0; // last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [31:0] diversity
	logic        m_tuser;        // [0] count_error
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [6:0]  cfg_wdata = '0;

	population_median_diversity i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the block state
	logic [31:0]  pos_mem [STORE_DEPTH];
	int           set_cnt = 0;
	int           agents_reg = 1;
	int           dims_reg = 1;
	coord_txn_t   coord_q [$];
	div_result_t  result_q [$];
	int           fail_cnt = 0;
	int           idle_cyc = 0;

	function automatic int eff_size(int v, int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Average over dimensions of mean absolute deviation from the upper median
	function automatic logic [31:0] median_diversity(int na, int nd);
		longint     col [MAX_AGENTS];
		longint     key, med, diff;
		longint unsigned sum, total;
		int         j;
		total = 0;
		for (int d = 0; d < nd; d++) begin
			for (int i = 0; i < na; i++)
				col[i] = longint'($signed(pos_mem[i * nd + d]));
			for (int i = 1; i < na; i++) begin
				key = col[i];
				j = i;
				while (j > 0 && col[j - 1] > key) begin
					col[j] = col[j - 1];
					j--;
				end
				col[j] = key;
			end
			med = col[na / 2];
			sum = 0;
			for (int i = 0; i < na; i++) begin
				diff = med - longint'($signed(pos_mem[i * nd + d]));
				sum += (diff < 0) ? -diff : diff;
			end
			total += sum / na;
		end
		return 32'(total / nd);
	endfunction

	// Update mirror on each accepted coordinate, queue the result on the last one
	function automatic void take_coord(coord_txn_t t);
		int          na, nd;
		div_result_t r;
		if (set_cnt < STORE_DEPTH) pos_mem[set_cnt] = t.coord;
		if (set_cnt < CNT_SAT) set_cnt++;
		if (!t.last) return;
		na = eff_size(agents_reg, MAX_AGENTS);
		nd = eff_size(dims_reg, MAX_DIMS);
		r.err = (set_cnt != na * nd);
		r.div = r.err ? 32'd0 : median_diversity(na, nd);
		if (t.fixed) begin
			r.div = t.fixed_div;
			r.err = t.fixed_err;
		end
		result_q = {result_q, r};
		set_cnt = 0;
	endfunction

	// Sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) take_coord(coord_q.pop_front());
			if (s_tvalid && !s_tready) begin
				// hold the waiting transaction
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (coord_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= coord_q[0].coord;
				s_tlast <= coord_q[0].last;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 200)
						: $urandom_range(0, 8);
					gap_left = $urandom_range(0, 4);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: checks each result under a stall pattern that is redrawn at random
	int stall_mode = 0;
	int rx_cyc = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$error("unexpected result diversity=%h count_error=%b", m_tdata, m_tuser);
					fail_cnt++;
				end else begin
					if (m_tdata !== result_q[0].div) begin
						$error("diversity: expected %h actual %h", result_q[0].div, m_tdata);
						fail_cnt++;
					end
					if (m_tuser !== result_q[0].err) begin
						$error("count_error: expected %b actual %b", result_q[0].err, m_tuser);
						fail_cnt++;
					end
					void'(result_q.pop_front());
				end
			end
			rx_cyc++;
			if (rx_cyc % 256 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_cyc % 5 == 0);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc = 0;
		else idle_cyc++;
		if (idle_cyc >= WDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic drain();
		wait (coord_q.size() == 0 && result_q.size() == 0);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= 7'(val);
		if (idx == REG_AGENT_COUNT) agents_reg = val & 'h7f;
		else if (idx == REG_DIM_COUNT) dims_reg = val & 'h3f;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_shape(int a, int d);
		drain();
		reg_write(REG_AGENT_COUNT, a);
		reg_write(REG_DIM_COUNT, d);
	endtask

	function automatic logic [31:0] gen_coord(int mode, logic [31:0] base);
		case (mode)
			0: return $urandom();
			1: return base + $urandom_range(0, 'h3ffff) - 'h20000;
			default: return base ^ ($urandom_range(0, 3) << 16);
		endcase
	endfunction

	// Queue one set of n coordinates, last on the final one
	task automatic push_set(int n);
		coord_txn_t  t;
		int          mode;
		logic [31:0] base;
		mode = $urandom_range(0, 2);
		base = $urandom();
		t.fixed = 1'b0;
		t.fixed_div = '0;
		t.fixed_err = 1'b0;
		for (int i = 0; i < n; i++) begin
			t.coord = gen_coord(mode, base);
			t.last = (i == n - 1);
			coord_q = {coord_q, t};
		end
	endtask

	dir_row_t dir_rows [] = '{
		'{1, 1, '{32'h0000_0000, 1'b1, 1'b1, 32'h0, 1'b0}},
		'{1, 1, '{32'h7fff_ffff, 1'b1, 1'b1, 32'h0, 1'b0}},
		'{1, 1, '{32'h8000_0000, 1'b1, 1'b1, 32'h0, 1'b0}},
		'{1, 1, '{32'hffff_ffff, 1'b1, 1'b1, 32'h0, 1'b0}},
		// short count is not possible with one item; too many items flags an error
		'{1, 1, '{32'h1234_5678, 1'b0, 1'b0, 32'h0, 1'b0}},
		'{1, 1, '{32'h9abc_def0, 1'b1, 1'b1, 32'h0, 1'b1}},
		// zero agents is taken as one
		'{0, 1, '{32'h5555_aaaa, 1'b1, 1'b1, 32'h0, 1'b0}},
		// widest spread: median is the upper value
		'{2, 1, '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0, 1'b0}},
		'{2, 1, '{32'h8000_0000, 1'b1, 1'b1, 32'h7fff_ffff, 1'b0}},
		'{2, 1, '{32'h0001_0000, 1'b1, 1'b1, 32'h0, 1'b1}},
		'{3, 2, '{32'h0003_0000, 1'b0, 1'b0, 32'h0, 1'b0}},
		'{3, 2, '{32'hfffe_0000, 1'b0, 1'b0, 32'h0, 1'b0}},
		'{3, 2, '{32'h0001_8000, 1'b0, 1'b0, 32'h0, 1'b0}},
		'{3, 2, '{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0}},
		'{3, 2, '{32'h0000_4000, 1'b0, 1'b0, 32'h0, 1'b0}},
		'{3, 2, '{32'hffff_ffff, 1'b1, 1'b0, 32'h0, 1'b0}}
	};

	initial begin
		int a, d, n, sent;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (int r = 0; r < dir_rows.size(); r++) begin
			if (dir_rows[r].agents != agents_reg || dir_rows[r].dims != dims_reg)
				set_shape(dir_rows[r].agents, dir_rows[r].dims);
			coord_q = {coord_q, dir_rows[r].txn};
		end

		// Extreme shapes, out-of-range settings and spare register indexes
		set_shape(64, 8);
		push_set(64 * 8);
		set_shape(127, 0);
		reg_write(REG_SPARE_A, 5);
		reg_write(REG_SPARE_B, 127);
		push_set(64);
		push_set(63);
		set_shape(0, 63);
		push_set(32);
		set_shape(1, 100);
		push_set(32);
		// overlong set flags an error, the next one is clean again
		set_shape(2, 2);
		push_set(9);
		push_set(4);

		// Random phases
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			if ($urandom_range(0, 7) == 0) begin
				a = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
				d = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
				if ($urandom_range(0, 1)) a = $urandom_range(1, 6);
				else d = $urandom_range(1, 4);
			end else begin
				a = $urandom_range(1, 9);
				d = $urandom_range(1, 5);
			end
			if ($urandom_range(0, 5) == 0) reg_write(REG_SPARE_A, $urandom_range(0, 127));
			reg_write(REG_AGENT_COUNT, a);
			reg_write(REG_DIM_COUNT, d);
			a = eff_size(a, MAX_AGENTS);
			d = eff_size(d, MAX_DIMS);
			repeat ($urandom_range(2, 6)) begin
				if (sent >= RANDOM_ITEMS) break;
				n = ($urandom_range(0, 99) < 85) ? a * d : $urandom_range(1, a * d + 4);
				push_set(n);
				sent += n;
			end
		end

		drain();
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/pmd_pkg.sv
sv/pmd_div.sv
sv/population_median_diversity.sv
dv/tb_top.sv
